FILE: sv/assert_macros.svh
// Assertion macros shared by the timer queue RTL.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with a label and a message.
`define DLTQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must never be true at a clock edge.
`define DLTQ_NEVER(label, cond, msg) \
	`DLTQ_ASSERT(label, !(cond), msg)

`endif

FILE: sv/dltq_pkg.sv
// Package for the delta list timer queue: sizes, request and micro-operation codes,
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int LINK_W     = IDX_W + 1;
	localparam int DT_W       = 18;
	localparam int ID_W       = 4;
	localparam int DUR_W      = 16;
	localparam int ARG_W      = 32;
	localparam int STEP_W     = 8;

	localparam logic [LINK_W-1:0] NIL_LINK        = LINK_W'(NUM_TIMERS);
	localparam logic [STEP_W-1:0] TICK_STEP_RESET = STEP_W'(5);

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2
	} dltq_req_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_REFUSE,
		OP_WALK_INIT,
		OP_WALK_STEP,
		OP_INSERT,
		OP_LINK,
		OP_TICK_SUB,
		OP_TICK_POP,
		OP_STOP_RD,
		OP_STOP_LINK,
		OP_EMIT
	} dltq_op_t;

	typedef struct packed {
		dltq_op_t op;
	} dltq_cmd_t;

	typedef struct packed {
		dltq_req_t req;
		logic      id_ok;
		logic      id_running;
		logic      head_nil;
		logic      expire;
		logic      walk_go;
		logic      out_free;
	} dltq_status_t;

	function automatic logic is_node(input logic [LINK_W-1:0] link);
		return link < NIL_LINK;
	endfunction

	function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] link);
		return is_node(link) ? link : NIL_LINK;
	endfunction

endpackage

`default_nettype wire

FILE: sv/dltq_ctrl.sv
// Sequencing state machine of the timer queue.
// Depends on dltq_pkg; drives one micro-operation per cycle, holding while the output is busy.
`timescale 1ns / 1ps
`default_nettype none

module dltq_ctrl
	import dltq_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire dltq_status_t status,
	output dltq_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK_SUB,
		ST_TICK_POP,
		ST_WALK,
		ST_INSERT,
		ST_LINK,
		ST_STOP_RD,
		ST_STOP_LINK,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (status.req)
					REQ_TICK: begin
						state_nxt = status.head_nil ? ST_DONE : ST_TICK_SUB;
					end
					REQ_START: begin
						if (!status.id_ok || status.id_running) begin
							cmd.op    = OP_REFUSE;
							state_nxt = ST_DONE;
						end else begin
							cmd.op    = OP_WALK_INIT;
							state_nxt = ST_WALK;
						end
					end
					REQ_STOP: begin
						if (!status.id_ok || !status.id_running) begin
							cmd.op    = OP_REFUSE;
							state_nxt = ST_DONE;
						end else begin
							state_nxt = ST_STOP_RD;
						end
					end
					default: begin
						state_nxt = ST_DONE;
					end
				endcase
			end
			ST_TICK_SUB: begin
				cmd.op    = OP_TICK_SUB;
				state_nxt = status.expire ? ST_TICK_POP : ST_DONE;
			end
			ST_TICK_POP: begin
				cmd.op    = OP_TICK_POP;
				state_nxt = ST_DONE;
			end
			ST_WALK: begin
				if (status.walk_go) begin
					cmd.op = OP_WALK_STEP;
				end else begin
					state_nxt = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.op    = OP_INSERT;
				state_nxt = ST_LINK;
			end
			ST_LINK: begin
				cmd.op    = OP_LINK;
				state_nxt = ST_DONE;
			end
			ST_STOP_RD: begin
				cmd.op    = OP_STOP_RD;
				state_nxt = ST_STOP_LINK;
			end
			ST_STOP_LINK: begin
				cmd.op    = OP_STOP_LINK;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.op    = OP_EMIT;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/dltq_datapath.sv
// Datapath of the timer queue: timer entry arrays, list head, walk registers,
// tick step register and the output register. Depends on dltq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dltq_datapath
	import dltq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dltq_cmd_t                cmd,
	output dltq_status_t                  status,
	input  wire logic [1:0]               req_type,
	input  wire logic [ID_W-1:0]          timer_id,
	input  wire logic [DUR_W-1:0]         duration_ms,
	input  wire logic signed [ARG_W-1:0]  user_arg,
	input  wire logic                     cfg_we,
	input  wire logic [STEP_W-1:0]        cfg_data,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          fired,
	output logic [ID_W-1:0]               fired_id,
	output logic signed [ARG_W-1:0]       fired_arg,
	output logic                          refused
);

	// Timer entries; contents are only meaningful for running timers.
	logic signed [DT_W-1:0]  delta_q [NUM_TIMERS];
	logic [LINK_W-1:0]       next_q  [NUM_TIMERS];
	logic [LINK_W-1:0]       prev_q  [NUM_TIMERS];
	logic signed [ARG_W-1:0] arg_q   [NUM_TIMERS];

	logic [NUM_TIMERS-1:0] running_q;
	logic [LINK_W-1:0]     head_q;
	logic [STEP_W-1:0]     tick_step_q;

	// Request captured at accept.
	dltq_req_t               req_q;
	logic [IDX_W-1:0]        id_q;
	logic                    id_ok_q;
	logic [DUR_W-1:0]        dur_q;
	logic signed [ARG_W-1:0] uarg_q;

	// Walk registers; a stop reuses them for next link, previous link and delta.
	logic signed [DT_W-1:0] t_q;
	logic [LINK_W-1:0]      p_q;
	logic [LINK_W-1:0]      last_q;

	// Result being built, and the output register.
	logic                    pend_fired_q;
	logic [ID_W-1:0]         pend_id_q;
	logic signed [ARG_W-1:0] pend_arg_q;
	logic                    pend_refused_q;
	logic                    out_valid_q;
	logic                    fired_q;
	logic [ID_W-1:0]         fired_id_q;
	logic signed [ARG_W-1:0] fired_arg_q;
	logic                    refused_q;

	logic [IDX_W-1:0]        rd_a;
	logic signed [DT_W-1:0]  rd_delta;
	logic [LINK_W-1:0]       rd_next;
	logic [LINK_W-1:0]       rd_prev;
	logic signed [ARG_W-1:0] rd_arg;
	logic signed [DT_W-1:0]  step_ext;
	logic signed [DT_W-1:0]  tick_new;

	logic                   dt_we;
	logic [IDX_W-1:0]       dt_wa;
	logic signed [DT_W-1:0] dt_wd;
	logic                   nx_we;
	logic [IDX_W-1:0]       nx_wa;
	logic [LINK_W-1:0]      nx_wd;
	logic                   pv_we;
	logic [IDX_W-1:0]       pv_wa;
	logic [LINK_W-1:0]      pv_wd;

	// One shared read address for all entry arrays.
	always_comb begin
		case (cmd.op)
			OP_TICK_SUB, OP_TICK_POP: rd_a = head_q[IDX_W-1:0];
			OP_STOP_RD:               rd_a = id_q;
			default:                  rd_a = p_q[IDX_W-1:0];
		endcase
	end

	assign rd_delta = delta_q[rd_a];
	assign rd_next  = next_q[rd_a];
	assign rd_prev  = prev_q[rd_a];
	assign rd_arg   = arg_q[rd_a];
	assign step_ext = $signed(DT_W'(tick_step_q));
	assign tick_new = rd_delta - step_ext;

	assign status.req        = req_q;
	assign status.id_ok      = id_ok_q;
	assign status.id_running = running_q[id_q];
	assign status.head_nil   = !is_node(head_q);
	assign status.expire     = tick_new[DT_W-1] || (tick_new == '0);
	assign status.walk_go    = is_node(p_q) && (t_q >= rd_delta);
	assign status.out_free   = !out_valid_q || !out_stall;

	// Write ports, one per array.
	always_comb begin
		dt_we = 1'b0;
		dt_wa = rd_a;
		dt_wd = tick_new;
		nx_we = 1'b0;
		nx_wa = last_q[IDX_W-1:0];
		nx_wd = LINK_W'(id_q);
		pv_we = 1'b0;
		pv_wa = p_q[IDX_W-1:0];
		pv_wd = LINK_W'(id_q);
		case (cmd.op)
			OP_TICK_SUB: begin
				dt_we = 1'b1;
			end
			OP_TICK_POP: begin
				pv_we = is_node(rd_next);
				pv_wa = rd_next[IDX_W-1:0];
				pv_wd = NIL_LINK;
			end
			OP_INSERT: begin
				dt_we = 1'b1;
				dt_wa = id_q;
				dt_wd = t_q;
				nx_we = 1'b1;
				nx_wa = id_q;
				nx_wd = p_q;
				pv_we = 1'b1;
				pv_wa = id_q;
				pv_wd = last_q;
			end
			OP_LINK: begin
				dt_we = is_node(p_q);
				dt_wd = rd_delta - t_q;
				nx_we = is_node(last_q);
				pv_we = is_node(p_q);
			end
			OP_STOP_LINK: begin
				dt_we = is_node(p_q);
				dt_wd = rd_delta + t_q;
				nx_we = is_node(last_q);
				nx_wd = p_q;
				pv_we = is_node(p_q);
				pv_wd = last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dt_we) begin
			delta_q[dt_wa] <= dt_wd;
		end
		if (nx_we) begin
			next_q[nx_wa] <= nx_wd;
		end
		if (pv_we) begin
			prev_q[pv_wa] <= pv_wd;
		end
		if (cmd.op == OP_INSERT) begin
			arg_q[id_q] <= uarg_q;
		end
	end

	// Request capture and walk registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				req_q   <= dltq_req_t'(req_type);
				id_q    <= IDX_W'(timer_id);
				id_ok_q <= (32'(timer_id) < 32'(NUM_TIMERS));
				dur_q   <= duration_ms;
				uarg_q  <= user_arg;
			end
			OP_WALK_INIT: begin
				t_q    <= $signed(DT_W'(dur_q) + DT_W'(tick_step_q));
				p_q    <= head_q;
				last_q <= NIL_LINK;
			end
			OP_WALK_STEP: begin
				t_q    <= t_q - rd_delta;
				last_q <= p_q;
				p_q    <= norm_link(rd_next);
			end
			OP_STOP_RD: begin
				t_q    <= rd_delta;
				p_q    <= norm_link(rd_next);
				last_q <= rd_prev;
			end
			default: begin
			end
		endcase
	end

	// List control, results and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q      <= '0;
			head_q         <= NIL_LINK;
			tick_step_q    <= TICK_STEP_RESET;
			pend_fired_q   <= 1'b0;
			pend_id_q      <= '0;
			pend_arg_q     <= '0;
			pend_refused_q <= 1'b0;
			out_valid_q    <= 1'b0;
			fired_q        <= 1'b0;
			fired_id_q     <= '0;
			fired_arg_q    <= '0;
			refused_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				tick_step_q <= cfg_data;
			end
			case (cmd.op)
				OP_LOAD: begin
					pend_fired_q   <= 1'b0;
					pend_id_q      <= '0;
					pend_arg_q     <= '0;
					pend_refused_q <= 1'b0;
				end
				OP_REFUSE: begin
					pend_refused_q <= 1'b1;
				end
				OP_TICK_POP: begin
					head_q                       <= norm_link(rd_next);
					running_q[head_q[IDX_W-1:0]] <= 1'b0;
					pend_fired_q                 <= 1'b1;
					pend_id_q                    <= ID_W'(head_q);
					pend_arg_q                   <= rd_arg;
				end
				OP_INSERT: begin
					running_q[id_q] <= 1'b1;
				end
				OP_LINK: begin
					if (!is_node(last_q)) begin
						head_q <= LINK_W'(id_q);
					end
				end
				OP_STOP_LINK: begin
					running_q[id_q] <= 1'b0;
					if (!is_node(last_q)) begin
						head_q <= p_q;
					end
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
				fired_q     <= pend_fired_q;
				fired_id_q  <= pend_id_q;
				fired_arg_q <= pend_arg_q;
				refused_q   <= pend_refused_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign fired     = fired_q;
	assign fired_id  = fired_id_q;
	assign fired_arg = fired_arg_q;
	assign refused   = refused_q;

endmodule

`default_nettype wire

FILE: sv/delta_list_timer_queue.sv
// Top level of the delta list timer queue: controller plus datapath.
// Depends on dltq_pkg, dltq_ctrl, dltq_datapath and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  req_type, timer_id, duration_ms, user_arg
//   out      output     out_valid/out_stall  fired, fired_id, fired_arg, refused
//   cfg      input      cfg_we               cfg_data (tick_step)
//
// After acceptance a tick goes from decode to done on an empty list, else through a
// subtract state and, if the head expires, a pop state; a stop goes through decode, a
// read and a relink state; a refused or unused request goes from decode to done. A start
// walks past the list entries ahead of it, reading one entry per cycle, then inserts and links.
// Reset clears the running marks, empties the list and sets tick_step to 5; the entry
// arrays are not cleared and need no clearing pass.
// The output register lets the block take a new request while a result still waits;
// a request finishes only once that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module delta_list_timer_queue
	import dltq_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              req_type,
	input  wire logic [ID_W-1:0]         timer_id,
	input  wire logic [DUR_W-1:0]        duration_ms,
	input  wire logic signed [ARG_W-1:0] user_arg,
	input  wire logic                    cfg_we,
	input  wire logic [STEP_W-1:0]       cfg_data,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         fired,
	output logic [ID_W-1:0]              fired_id,
	output logic signed [ARG_W-1:0]      fired_arg,
	output logic                         refused
);

	dltq_cmd_t    cmd;
	dltq_status_t status;

	// The controller steps through one micro-operation per cycle, holding while the output is busy.
	dltq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the list and performs each micro-operation.
	dltq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_type    (req_type),
		.timer_id    (timer_id),
		.duration_ms (duration_ms),
		.user_arg    (user_arg),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fired       (fired),
		.fired_id    (fired_id),
		.fired_arg   (fired_arg),
		.refused     (refused)
	);

	// After a request is accepted the block is busy in the next cycle.
	`DLTQ_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "not busy after accept")
	// A result never both reports an expiry and a refusal.
	`DLTQ_NEVER(a_fired_refused, out_valid && fired && refused, "fired and refused together")
	// Loading the output register always presents a result.
	`DLTQ_ASSERT(a_emit_valid, (cmd.op == OP_EMIT) |=> out_valid, "emitted result not valid")
	// Expiry only removes a head from a non-empty list.
	`DLTQ_NEVER(a_pop_empty, (cmd.op == OP_TICK_POP) && status.head_nil, "pop on empty list")

endmodule

`default_nettype wire

FILE: tb/timer_report_checker.sv
// Checker for the delta list timer queue: watches the request, result and tick_step ports,
// keeps its own copy of the timer list and compares every result with the expected one.
// Depends on dltq_pkg for sizes and request codes.
`timescale 1ns / 1ps

module timer_report_checker
	import dltq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [1:0]              req_type,
	input  logic [ID_W-1:0]         timer_id,
	input  logic [DUR_W-1:0]        duration_ms,
	input  logic signed [ARG_W-1:0] user_arg,
	input  logic                    cfg_we,
	input  logic [STEP_W-1:0]       cfg_data,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic                    fired,
	input  logic [ID_W-1:0]         fired_id,
	input  logic signed [ARG_W-1:0] fired_arg,
	input  logic                    refused,
	output int                      mismatches,
	output int                      reports_left
);

	typedef struct packed {
		logic                    fired;
		logic [ID_W-1:0]         id;
		logic signed [ARG_W-1:0] arg;
		logic                    refused;
	} timer_report_t;

	// Shadow of the timer list. A link value of NUM_TIMERS means no entry.
	int                      slot_delta [NUM_TIMERS];
	bit                      slot_live  [NUM_TIMERS];
	int                      link_fwd   [NUM_TIMERS];
	int                      link_back  [NUM_TIMERS];
	logic signed [ARG_W-1:0] slot_arg   [NUM_TIMERS];
	int                      list_head;
	int                      step_ms;

	timer_report_t reports_due[$];

	function automatic void clear_list();
		for (int i = 0; i < NUM_TIMERS; i++) begin
			slot_delta[i] = 0;
			slot_live[i]  = 1'b0;
			link_fwd[i]   = NUM_TIMERS;
			link_back[i]  = NUM_TIMERS;
			slot_arg[i]   = '0;
		end
		list_head = NUM_TIMERS;
		step_ms   = int'(TICK_STEP_RESET);
	endfunction

	// Insert behind every entry whose expiry is not later, then trim the follower.
	function automatic void arm_timer(int id, int dur, logic signed [ARG_W-1:0] arg);
		int  remain;
		int  cur;
		int  last;
		int  walked;
		bit  found;
		int  pv;
		remain = dur + step_ms;
		cur    = list_head;
		last   = NUM_TIMERS;
		walked = 0;
		found  = 1'b0;
		while (!found && cur < NUM_TIMERS && walked < NUM_TIMERS) begin
			if (remain < slot_delta[cur]) begin
				found = 1'b1;
			end else begin
				remain -= slot_delta[cur];
				last    = cur;
				cur     = link_fwd[cur];
				walked++;
			end
		end
		if (cur >= NUM_TIMERS)
			cur = NUM_TIMERS;
		slot_delta[id] = remain;
		slot_live[id]  = 1'b1;
		slot_arg[id]   = arg;
		if (cur == NUM_TIMERS) begin
			link_fwd[id]  = NUM_TIMERS;
			link_back[id] = last;
			if (last < NUM_TIMERS)
				link_fwd[last] = id;
			else
				list_head = id;
		end else begin
			pv = link_back[cur];
			slot_delta[cur] -= remain;
			link_fwd[id]  = cur;
			link_back[id] = pv;
			if (pv < NUM_TIMERS)
				link_fwd[pv] = id;
			else
				list_head = id;
			link_back[cur] = id;
		end
	endfunction

	function automatic void disarm_timer(int id);
		int nx;
		int pv;
		nx = link_fwd[id];
		pv = link_back[id];
		if (nx < NUM_TIMERS) begin
			slot_delta[nx] += slot_delta[id];
			link_back[nx]   = pv;
		end else begin
			nx = NUM_TIMERS;
		end
		if (pv < NUM_TIMERS)
			link_fwd[pv] = nx;
		else
			list_head = nx;
		slot_live[id] = 1'b0;
		link_fwd[id]  = NUM_TIMERS;
		link_back[id] = NUM_TIMERS;
	endfunction

	function automatic timer_report_t apply_request(logic [1:0] req, int id, int dur,
			logic signed [ARG_W-1:0] arg);
		timer_report_t rep;
		int            hd;
		int            nx;
		rep = '0;
		case (req)
			REQ_TICK: begin
				hd = list_head;
				if (hd < NUM_TIMERS) begin
					slot_delta[hd] -= step_ms;
					if (slot_delta[hd] <= 0) begin
						nx = link_fwd[hd];
						if (nx < NUM_TIMERS) begin
							link_back[nx] = NUM_TIMERS;
							list_head     = nx;
						end else begin
							list_head = NUM_TIMERS;
						end
						slot_live[hd] = 1'b0;
						rep.fired     = 1'b1;
						rep.id        = ID_W'(hd);
						rep.arg       = slot_arg[hd];
					end
				end
			end
			REQ_START: begin
				if (id >= NUM_TIMERS || slot_live[id])
					rep.refused = 1'b1;
				else
					arm_timer(id, dur, arg);
			end
			REQ_STOP: begin
				if (id >= NUM_TIMERS || !slot_live[id])
					rep.refused = 1'b1;
				else
					disarm_timer(id);
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	function automatic void note_mismatch(string field, longint want, longint got);
		$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_report_t want;
		if (!arst_n) begin
			clear_list();
			reports_due.delete();
			mismatches   = 0;
			reports_left = 0;
		end else begin
			// Results are checked before the request of this edge is predicted, since no
			// request can come back in the same cycle it is taken.
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					$display("%0t: expected no result, got fired %0b id %0d arg %0d refused %0b",
						$time, fired, fired_id, fired_arg, refused);
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					if (fired !== want.fired)
						note_mismatch("fired", want.fired, fired);
					if (fired_id !== want.id)
						note_mismatch("fired_id", want.id, fired_id);
					if (fired_arg !== want.arg)
						note_mismatch("fired_arg", want.arg, fired_arg);
					if (refused !== want.refused)
						note_mismatch("refused", want.refused, refused);
				end
			end
			if (in_valid && !in_stall)
				reports_due.push_back(apply_request(req_type, int'(timer_id),
					int'(duration_ms), user_arg));
			if (cfg_we)
				step_ms = int'(cfg_data);
			reports_left = reports_due.size();
		end
	end

endmodule

FILE: tb/delta_list_timer_queue_test.sv
// Top of the delta list timer queue testbench: clock, reset, request and result traffic,
// tick_step writes and the verdict. Depends on dltq_pkg, timer_report_checker and the RTL.
`timescale 1ns / 1ps

module delta_list_timer_queue_test;
	import dltq_pkg::*;

	// The request code the block leaves unused; it must come back with all fields zero.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Cycles to let pass once the last result is in before a tick_step write. This leaves a
	// fair margin over the time that a start which walks the whole list needs.
	localparam int SETTLE_CYCLES = 2 * NUM_TIMERS + 8;

	// Random requests per tick_step setting; the last setting runs with no idling at all.
	localparam int ITEMS_PER_PHASE = 75;
	localparam int NUM_PHASES      = 6;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              req_type;
	logic [ID_W-1:0]         timer_id;
	logic [DUR_W-1:0]        duration_ms;
	logic signed [ARG_W-1:0] user_arg;
	logic                    cfg_we;
	logic [STEP_W-1:0]       cfg_data;
	logic                    out_valid;
	logic                    out_stall;
	logic                    fired;
	logic [ID_W-1:0]         fired_id;
	logic signed [ARG_W-1:0] fired_arg;
	logic                    refused;

	int mismatches;
	int reports_left;
	int results_taken;
	bit quiet;

	always #4 clk = ~clk;

	delta_list_timer_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.timer_id   (timer_id),
		.duration_ms(duration_ms),
		.user_arg   (user_arg),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.fired      (fired),
		.fired_id   (fired_id),
		.fired_arg  (fired_arg),
		.refused    (refused)
	);

	timer_report_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.timer_id    (timer_id),
		.duration_ms (duration_ms),
		.user_arg    (user_arg),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fired       (fired),
		.fired_id    (fired_id),
		.fired_arg   (fired_arg),
		.refused     (refused),
		.mismatches  (mismatches),
		.reports_left(reports_left)
	);

	// Results taken by the receiver so far; the long hold-off below keys off this count.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			results_taken <= 0;
		else if (out_valid && !out_stall)
			results_taken <= results_taken + 1;
	end

	// Receiver. It stalls in random bursts, and once, early in the random part, it holds
	// off while the sender keeps offering requests, so that the output register fills and
	// the block has to stall its input. The stall value is decided once per falling edge
	// from a countdown, so it is assigned only once in any time step.
	initial begin : receiver
		int  stall_left;
		bit  held_off;
		stall_left = 0;
		held_off   = 1'b0;
		out_stall  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (!held_off && results_taken >= 60) begin
				held_off   = 1'b1;
				stall_left = 300;
			end else if (!quiet && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 12);
			out_stall <= (stall_left > 0);
		end
	end

	// Offers one request and returns at the rising edge where the block takes it. The
	// fields stay put while the block stalls, and valid is not touched between two
	// back-to-back requests, so it simply stays high.
	task automatic issue_request(input logic [1:0] req, input logic [ID_W-1:0] id,
			input logic [DUR_W-1:0] dur, input logic signed [ARG_W-1:0] arg);
		@(negedge clk);
		in_valid    <= 1'b1;
		req_type    <= req;
		timer_id    <= id;
		duration_ms <= dur;
		user_arg    <= arg;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic idle_input(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Drops valid, waits until every expected result has come back, and then gives the
	// block the time a full list walk would need, so the block is really idle afterwards.
	task automatic drain_reports();
		@(negedge clk);
		in_valid <= 1'b0;
		while (reports_left != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_tick_step(input logic [STEP_W-1:0] step);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= step;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Mostly short durations, so timers actually expire within the run; now and then a
	// duration over the full 16-bit range so every bit of the field gets exercised. Ticks
	// and stops carry random values in the fields they ignore.
	task automatic random_request();
		int               pick;
		logic [1:0]       req;
		logic [DUR_W-1:0] dur;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			dur = DUR_W'($urandom());
		else
			dur = DUR_W'($urandom_range(0, 40));
		if (pick < 45)
			req = REQ_TICK;
		else if (pick < 80)
			req = REQ_START;
		else if (pick < 95)
			req = REQ_STOP;
		else
			req = REQ_UNUSED;
		issue_request(req, ID_W'($urandom()), dur, $urandom());
	endtask

	initial begin : stimulus
		logic [STEP_W-1:0] phase_steps [NUM_PHASES];
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		req_type    = REQ_TICK;
		timer_id    = '0;
		duration_ms = '0;
		user_arg    = '0;
		cfg_we      = 1'b0;
		cfg_data    = '0;
		quiet       = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, run with tick_step at its reset value of 5.
		// A tick on an empty list fires nothing, and a stop of an idle timer is refused.
		issue_request(REQ_TICK, 4'd9, 16'hFFFF, 32'sh7FFF_FFFF);
		issue_request(REQ_STOP, 4'd3, 16'd0, 32'sd0);
		// The unused request code is ignored, whatever the other fields hold.
		issue_request(REQ_UNUSED, 4'hF, 16'hFFFF, -32'sd1);
		// Timer 0 gets the largest argument; a second start while running is refused.
		issue_request(REQ_START, 4'd0, 16'd0, 32'sh7FFF_FFFF);
		issue_request(REQ_START, 4'd0, 16'd7, 32'sd1);
		// Timer 15 expires at the same time as timer 0, so it goes behind it with a zero delta.
		issue_request(REQ_START, 4'd15, 16'd0, 32'sh8000_0000);
		// The longest duration lands at the tail.
		issue_request(REQ_START, 4'd7, 16'hFFFF, -32'sd1);
		// Timer 4 goes in ahead of timer 7 and trims its delta; stopping it hands the time back.
		issue_request(REQ_START, 4'd4, 16'd10, 32'sh1234_5678);
		issue_request(REQ_STOP, 4'd4, 16'd0, 32'sd0);
		// The stop cleared the running mark, so a second stop is refused.
		issue_request(REQ_STOP, 4'd4, 16'd0, 32'sd0);
		// Timer 0 fires, then timer 15 with its zero delta on the next tick, then nothing.
		issue_request(REQ_TICK, 4'd0, 16'd0, 32'sd0);
		issue_request(REQ_TICK, 4'd0, 16'd0, 32'sd0);
		issue_request(REQ_TICK, 4'd0, 16'd0, 32'sd0);
		// A stopped timer can be started again.
		issue_request(REQ_START, 4'd4, 16'd3, 32'sh55AA_55AA);
		issue_request(REQ_TICK, 4'd0, 16'd0, 32'sd0);
		issue_request(REQ_TICK, 4'd0, 16'd0, 32'sd0);
		// Stopping the last timer empties the list again.
		issue_request(REQ_STOP, 4'd7, 16'd0, 32'sd0);
		issue_request(REQ_TICK, 4'd0, 16'd0, 32'sd0);
		issue_request(REQ_START, 4'd10, 16'hAAAA, 32'sh5555_5555);
		issue_request(REQ_START, 4'd5, 16'h5555, -32'sh5555_5556);
		drain_reports();

		// Random part, one phase per tick_step setting. A step of zero lets only timers with a
		// zero delta fire, so the list fills and many starts are refused there. The last
		// phase returns to the reset value and runs without any idling.
		phase_steps[0] = 8'd1;
		phase_steps[1] = 8'd255;
		phase_steps[2] = 8'd0;
		phase_steps[3] = STEP_W'($urandom_range(2, 254));
		phase_steps[4] = 8'd128;
		phase_steps[5] = TICK_STEP_RESET;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			write_tick_step(phase_steps[phase]);
			quiet = (phase == NUM_PHASES - 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				random_request();
				if (!quiet && $urandom_range(0, 4) == 0)
					idle_input($urandom_range(1, 12));
			end
			drain_reports();
		end

		if (mismatches == 0 && reports_left == 0)
			$display("delta_list_timer_queue_test OK");
		else
			$display("delta_list_timer_queue_test NOT OK");
		$finish;
	end

	// A correct run needs well under a tenth of this time.
	initial begin : watchdog
		#2_000_000;
		$display("delta_list_timer_queue_test NOT OK");
		$finish;
	end

endmodule

FILE: delta_list_timer_queue.f
+incdir+sv
sv/dltq_pkg.sv
sv/dltq_ctrl.sv
sv/dltq_datapath.sv
sv/delta_list_timer_queue.sv
tb/timer_report_checker.sv
tb/delta_list_timer_queue_test.sv
